>>> sv/tot_pkg.sv
// Shared types and constants of the thruster on-time block.
`default_nettype none
package tot_pkg;

	localparam int NUM_THRUSTERS = 8;

	localparam int FORCE_W  = 24;
	localparam int THRUST_W = 23;
	localparam int PERIOD_W = 24;
	localparam int FACTOR_W = 16;
	localparam int REM_W    = 16;
	localparam int ONTIME_W = 28;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] ACT_FIRE   = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FIRE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_PULSE = 2'd3;

	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 24'd100000;
	localparam logic [PERIOD_W-1:0] MIN_FIRE_RST = 24'd20000;
	localparam logic [FACTOR_W-1:0] FACTOR_RST   = 16'd4096;
	localparam logic [ONTIME_W-1:0] SAT_RST      = 28'd100000;

	localparam int DIV1_STEPS = 24;
	localparam int DIV2_STEPS = 16;

	typedef struct packed {
		logic                 fire;
		logic                 clr;
		logic [IDX_W-1:0]     idx;
		logic                 last;
		logic [FORCE_W-1:0]   force_mn;
		logic [THRUST_W-1:0]  maxt;
		logic [23:0]          f;
		logic [47:0]          num;
		logic                 ovf;
		logic [24:0]          pr;
		logic [23:0]          q;
		logic [39:0]          prod;
		logic                 lt;
		logic                 sat;
		logic [23:0]          t;
	} pl_t;

endpackage
`default_nettype wire

>>> sv/tot_if.sv
// Handshake interfaces for commands, results and configuration writes.
`default_nettype none
interface tot_cmd_if import tot_pkg::*;;
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	logic [IDX_W-1:0]    thruster_index;
	logic signed [FORCE_W-1:0] force_mn;
	logic [THRUST_W-1:0] max_thrust_mn;
	logic                last;
	modport source (output valid, action, thruster_index, force_mn, max_thrust_mn, last,
		input ready);
	modport sink (input valid, action, thruster_index, force_mn, max_thrust_mn, last,
		output ready);
endinterface

interface tot_res_if import tot_pkg::*;;
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    thruster_number;
	logic [ONTIME_W-1:0] on_time_us;
	logic                end_of_step;
	modport source (output valid, thruster_number, on_time_us, end_of_step, input ready);
	modport sink (input valid, thruster_number, on_time_us, end_of_step, output ready);
endinterface

interface tot_cfg_if import tot_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/thruster_on_time_remainder.sv
// Throughput: one request per cycle unless the output stalls; a fire request waits
// while a request for its thruster or a clear is past the remainder read stage.
// The 24-step quotient pipeline and the 16-step remainder pipeline set the depth.
// Reset clears all valid bits, the remainders and sets registers to their defaults.
// Thruster on-time pipeline with remainder tracking.
`default_nettype none
module thruster_on_time_remainder import tot_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	tot_cmd_if.sink   cmd,
	tot_res_if.source res,
	tot_cfg_if.sink   cfg
);

	localparam int IW     = (NUM_THRUSTERS > 1) ? $clog2(NUM_THRUSTERS) : 1;
	localparam int S_IN   = 0;
	localparam int S_F    = 1;
	localparam int S_N    = 2;
	localparam int S_D0   = 3;
	localparam int S_Q    = S_D0 + DIV1_STEPS;
	localparam int S_R    = S_Q + 1;
	localparam int S_T    = S_R + 1;
	localparam int S_LAST = S_T + DIV2_STEPS;
	localparam int NS     = S_LAST + 1;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] min_fire_q;
	logic [FACTOR_W-1:0] factor_q;
	logic                off_q;
	logic [ONTIME_W-1:0] sat_q;

	logic [THRUST_W-1:0] mt_tbl [NUM_THRUSTERS];
	logic [REM_W-1:0]    rem_tbl [NUM_THRUSTERS];

	pl_t        stg [NS];
	pl_t        nxt [NS];
	logic [NS-1:0] v_q;
	logic       haz, en_up, en_dn, idx_ok, cmd_acc;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RST;
			min_fire_q <= MIN_FIRE_RST;
			factor_q   <= FACTOR_RST;
			off_q      <= 1'b0;
			sat_q      <= SAT_RST;
		end else begin
			sat_q <= ONTIME_W'((40'(factor_q) * 40'(period_q)) >> 12);
			if (cfg.valid) begin
				case (cfg.index)
					REG_PERIOD:    period_q   <= cfg.data[PERIOD_W-1:0];
					REG_MIN_FIRE:  min_fire_q <= cfg.data[PERIOD_W-1:0];
					REG_FACTOR:    factor_q   <= cfg.data[FACTOR_W-1:0];
					REG_OFF_PULSE: off_q      <= cfg.data[0];
					default: ;
				endcase
			end
		end
	end

	assign idx_ok  = (7'(cmd.thruster_index) < 7'(NUM_THRUSTERS));
	assign cmd_acc = cmd.valid && en_up;

	always_ff @(posedge clk) begin
		if (cmd_acc && cmd.action == ACT_LOAD && idx_ok) begin
			mt_tbl[IW'(cmd.thruster_index)] <= cmd.max_thrust_mn;
		end
	end

	always_comb begin
		pl_t tmp;
		logic signed [25:0] fs;
		logic [24:0] sh;
		logic [24:0] tsum;
		logic qb;
		tmp  = '0;
		fs   = '0;
		sh   = '0;
		tsum = '0;
		qb   = 1'b0;
		tmp.fire     = (cmd.action == ACT_FIRE) && idx_ok;
		tmp.clr      = (cmd.action == ACT_CLEAR);
		tmp.idx      = cmd.thruster_index;
		tmp.last     = cmd.last;
		tmp.force_mn = cmd.force_mn;
		nxt[S_IN]    = tmp;

		tmp      = stg[S_IN];
		tmp.maxt = mt_tbl[IW'(tmp.idx)];
		fs = {{2{tmp.force_mn[FORCE_W-1]}}, tmp.force_mn}
			+ (off_q ? {3'b000, tmp.maxt} : 26'sd0);
		tmp.f    = fs[25] ? 24'd0 : fs[23:0];
		nxt[S_F] = tmp;

		tmp      = stg[S_F];
		tmp.num  = 48'(tmp.f) * 48'(period_q);
		nxt[S_N] = tmp;

		tmp       = stg[S_N];
		tmp.ovf   = (tmp.num[47:24] >= {1'b0, tmp.maxt});
		tmp.pr    = {1'b0, tmp.num[47:24]};
		tmp.q     = '0;
		nxt[S_D0] = tmp;

		for (int j = 0; j < DIV1_STEPS; j++) begin
			tmp = stg[S_D0 + j];
			sh  = {tmp.pr[23:0], tmp.num[DIV1_STEPS-1-j]};
			qb  = (sh >= {2'b00, tmp.maxt});
			tmp.pr = qb ? (sh - {2'b00, tmp.maxt}) : sh;
			tmp.q  = {tmp.q[22:0], qb};
			nxt[S_D0 + j + 1] = tmp;
		end

		tmp      = stg[S_Q];
		tmp.prod = 40'(rem_tbl[IW'(tmp.idx)]) * 40'(min_fire_q);
		nxt[S_R] = tmp;

		tmp      = stg[S_R];
		tsum     = {1'b0, tmp.q} + {1'b0, tmp.prod[39:16]};
		tmp.lt   = !tmp.ovf && (tsum < {1'b0, min_fire_q});
		tmp.sat  = tmp.ovf || (tsum >= {1'b0, period_q});
		tmp.t    = tsum[23:0];
		tmp.pr   = tsum;
		tmp.q    = '0;
		nxt[S_T] = tmp;

		for (int j = 0; j < DIV2_STEPS; j++) begin
			tmp = stg[S_T + j];
			sh  = {tmp.pr[23:0], 1'b0};
			qb  = (sh >= {1'b0, min_fire_q});
			tmp.pr = qb ? (sh - {1'b0, min_fire_q}) : sh;
			tmp.q  = {tmp.q[22:0], qb};
			nxt[S_T + j + 1] = tmp;
		end
	end

	always_comb begin
		haz = 1'b0;
		if (v_q[S_Q] && stg[S_Q].fire) begin
			for (int k = S_R; k < NS; k++) begin
				if (v_q[k] && (stg[k].clr || (stg[k].fire && stg[k].idx == stg[S_Q].idx))) begin
					haz = 1'b1;
				end
			end
		end
	end

	assign en_dn     = !(v_q[S_LAST] && stg[S_LAST].fire && !res.ready);
	assign en_up     = en_dn && !haz;
	assign cmd.ready = en_up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en_up) begin
				v_q[S_IN] <= cmd.valid && (nxt[S_IN].fire || nxt[S_IN].clr);
				for (int k = 1; k <= S_Q; k++) begin
					v_q[k] <= v_q[k-1];
				end
			end
			if (en_dn) begin
				v_q[S_R] <= v_q[S_Q] && !haz;
				for (int k = S_R + 1; k < NS; k++) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_up) begin
			for (int k = 0; k <= S_Q; k++) begin
				stg[k] <= nxt[k];
			end
		end
		if (en_dn) begin
			for (int k = S_R; k < NS; k++) begin
				stg[k] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_THRUSTERS; k++) begin
				rem_tbl[k] <= '0;
			end
		end else if (en_dn && v_q[S_LAST]) begin
			if (stg[S_LAST].clr) begin
				for (int k = 0; k < NUM_THRUSTERS; k++) begin
					rem_tbl[k] <= '0;
				end
			end else if (stg[S_LAST].fire) begin
				rem_tbl[IW'(stg[S_LAST].idx)] <= stg[S_LAST].lt ? stg[S_LAST].q[REM_W-1:0] : '0;
			end
		end
	end

	assign res.valid           = v_q[S_LAST] && stg[S_LAST].fire;
	assign res.thruster_number = stg[S_LAST].idx;
	assign res.end_of_step     = stg[S_LAST].last;
	assign res.on_time_us      = stg[S_LAST].lt  ? '0 :
	                             stg[S_LAST].sat ? sat_q : {4'b0000, stg[S_LAST].t};

endmodule
`default_nettype wire

>>> sv/tot_checker.sv
// Port-level checks of the thruster on-time block and their binding.
`default_nettype none
module tot_checker import tot_pkg::*; (
	input wire                clk,
	input wire                arst_n,
	input wire                cmd_valid,
	input wire                cmd_ready,
	input wire [1:0]          cmd_action,
	input wire [IDX_W-1:0]    cmd_index,
	input wire                res_valid,
	input wire                res_ready,
	input wire [IDX_W-1:0]    res_number,
	input wire [ONTIME_W-1:0] res_on_time
);

	logic [6:0] pend_q;
	logic       fire_acc, res_acc;

	assign fire_acc = cmd_valid && cmd_ready && cmd_action == ACT_FIRE
		&& (7'(cmd_index) < 7'(NUM_THRUSTERS));
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 7'(fire_acc) - 7'(res_acc);
		end
	end

	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !res_valid)
		else $error("result shown right after reset");
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 7'd0)
		else $error("result without a pending fire request");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_on_time) && $stable(res_number))
		else $error("result changed while stalled");

endmodule

bind thruster_on_time_remainder tot_checker u_tot_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_action  (cmd.action),
	.cmd_index   (cmd.thruster_index),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_number  (res.thruster_number),
	.res_on_time (res.on_time_us)
);
`default_nettype wire

>>> tb/tb_thruster_checker.sv
`timescale 1ns / 1ps
// Checker that predicts thruster on-times from observed requests and compares results.
module tb_thruster_checker import tot_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	tot_cmd_if        cmd,
	tot_res_if        res,
	tot_cfg_if        cfg,
	output int        fail_count,
	output int        pending
);

	typedef struct {
		logic [IDX_W-1:0]    number;
		logic [ONTIME_W-1:0] on_time;
		logic                eos;
	} on_time_t;

	on_time_t                   on_time_q[$];
	logic [PERIOD_W-1:0]        period;
	logic [PERIOD_W-1:0]        min_fire;
	logic [FACTOR_W-1:0]        factor;
	logic                       off_pulse;
	logic [REM_W-1:0]           remainder[8];
	logic [THRUST_W-1:0]        max_thrust[8];

	function automatic logic [ONTIME_W-1:0] on_time_of(input logic [IDX_W-1:0] idx,
		input logic signed [FORCE_W-1:0] force_in);
		longint signed f;
		longint unsigned fu, base, t, maxt;
		maxt = max_thrust[idx];
		f = force_in;
		if (off_pulse)
			f = f + longint'(maxt);
		fu = (f < 0) ? 0 : f;
		if (maxt == 0)
			base = 64'hFFFF_FFFF_FFFF;
		else
			base = (fu * period) / maxt;
		t = base + ((longint'(remainder[idx]) * min_fire) >> 16);
		remainder[idx] = '0;
		if (t < min_fire) begin
			remainder[idx] = REM_W'((t << 16) / min_fire);
			return '0;
		end
		if (t >= period)
			return ONTIME_W'((longint'(factor) * period) >> 12);
		return ONTIME_W'(t);
	endfunction

	assign pending = on_time_q.size();

	always @(posedge clk or negedge arst_n) begin
		on_time_t want;
		if (!arst_n) begin
			period <= PERIOD_RST;
			min_fire <= MIN_FIRE_RST;
			factor <= FACTOR_RST;
			off_pulse <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				remainder[i] = '0;
				max_thrust[i] = '0;
			end
			on_time_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PERIOD: period <= cfg.data;
					REG_MIN_FIRE: min_fire <= cfg.data;
					REG_FACTOR: factor <= cfg.data[FACTOR_W-1:0];
					REG_OFF_PULSE: off_pulse <= cfg.data[0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				case (cmd.action)
					ACT_CLEAR: for (int i = 0; i < 8; i++) remainder[i] = '0;
					ACT_LOAD: max_thrust[cmd.thruster_index] = cmd.max_thrust_mn;
					ACT_FIRE: begin
						want.number = cmd.thruster_index;
						want.on_time = on_time_of(cmd.thruster_index, cmd.force_mn);
						want.eos = cmd.last;
						on_time_q.push_back(want);
					end
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (on_time_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
						$time, res.thruster_number, res.on_time_us, res.end_of_step);
					fail_count <= fail_count + 1;
				end else begin
					want = on_time_q.pop_front();
					if (want.number !== res.thruster_number || want.on_time !== res.on_time_us
						|| want.eos !== res.end_of_step) begin
						$display("%0t: mismatch: expected %0d/%0d/%0d, actual %0d/%0d/%0d",
							$time, want.number, want.on_time, want.eos,
							res.thruster_number, res.on_time_us, res.end_of_step);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/tb_thruster_on_time_remainder.sv
`timescale 1ns / 1ps
// Top-level testbench driving requests and settings into the thruster on-time block.
module tb_thruster_on_time_remainder;
	import tot_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	int   gap_left;
	int   burst_left;
	int   stall_mode;

	tot_cmd_if cmd();
	tot_res_if res();
	tot_cfg_if cfg();

	thruster_on_time_remainder uut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res), .cfg(cfg));
	tb_thruster_checker chk (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res), .cfg(cfg),
		.fail_count(fail_count), .pending(pending));

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (cycles % 4000 < 1500)
			res.ready <= 1'b1;
		else if (stall_mode == 0)
			res.ready <= ($urandom_range(0, 3) != 0);
		else
			res.ready <= ($urandom_range(0, 9) < 3);
		if (cycles % 997 == 0)
			stall_mode <= $urandom_range(0, 1);
	end

	task automatic send(input logic [1:0] action, input logic [IDX_W-1:0] idx,
		input logic signed [FORCE_W-1:0] force_in, input logic [THRUST_W-1:0] maxt,
		input logic last_in);
		if (burst_left == 0) begin
			gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
		end
		if (gap_left > 0)
			cmd.valid <= 1'b0;
		while (gap_left > 0) begin
			@(negedge clk);
			gap_left--;
		end
		burst_left--;
		cmd.valid <= 1'b1;
		cmd.action <= action;
		cmd.thruster_index <= idx;
		cmd.force_mn <= force_in;
		cmd.max_thrust_mn <= maxt;
		cmd.last <= last_in;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic fire_random(input int mode);
		logic signed [FORCE_W-1:0] f;
		case ($urandom_range(0, 5))
			0: f = FORCE_W'($urandom);
			1: f = -$signed({1'b0, 23'($urandom_range(0, 5000))});
			default: f = FORCE_W'($urandom_range(0, mode ? 2000 : 200000));
		endcase
		send(ACT_FIRE, IDX_W'($urandom_range(0, 7)), f, THRUST_W'($urandom),
			1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [CFG_W-1:0] periods[4];
		logic [CFG_W-1:0] mins[4];
		int r;
		cycles = 0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.action = ACT_FIRE;
		cmd.thruster_index = '0;
		cmd.force_mn = '0;
		cmd.max_thrust_mn = '0;
		cmd.last = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_PERIOD;
		cfg.data = '0;
		res.ready = 1'b1;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < 8; i++)
			send(ACT_LOAD, IDX_W'(i), '0,
				(i == 0) ? 23'h7FFFFF : (i == 1) ? 23'd1 : THRUST_W'(10000 + i), 1'b0);
		send(ACT_FIRE, 3'd0, 24'sh7FFFFF, '0, 1'b0);
		send(ACT_FIRE, 3'd1, 24'sh7FFFFF, '0, 1'b1);
		send(ACT_FIRE, 3'd2, -24'sh800000, '0, 1'b0);
		send(ACT_FIRE, 3'd3, 24'sd1000, '0, 1'b0);
		send(ACT_FIRE, 3'd3, 24'sd1000, '0, 1'b0);
		send(ACT_FIRE, 3'd3, 24'sd1500, '0, 1'b1);
		send(ACT_CLEAR, 3'd0, '0, '0, 1'b0);
		send(ACT_FIRE, 3'd3, 24'sd1000, '0, 1'b0);
		send(ACT_UNUSED, 3'd4, 24'sd5, 23'd5, 1'b1);
		send(ACT_FIRE, 3'd4, 24'sd10004, 23'h555555, 1'b1);
		send(ACT_FIRE, 3'd5, 24'sd20000, '0, 1'b0);
		drain();

		periods = '{24'd1, 24'd100000, 24'd10000000, 24'hFFFFFF};
		mins = '{24'd1, 24'd20000, 24'd0, 24'hFFFFFF};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_PERIOD, (ph == 7) ? 24'd0 : periods[ph % 4]);
			write_reg(REG_MIN_FIRE, mins[(ph + 1) % 4]);
			write_reg(REG_FACTOR, (ph == 1) ? 24'd65535 : (ph == 2) ? 24'd0 :
				CFG_W'($urandom_range(0, 65535)));
			write_reg(REG_OFF_PULSE, CFG_W'(ph % 2));
			if (ph == 3)
				send(ACT_LOAD, 3'd6, '0, '0, 1'b0);
			else
				send(ACT_LOAD, 3'd6, '0, THRUST_W'($urandom_range(1, 23'h7FFFFF)), 1'b0);
			for (int n = 0; n < 225; n++) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					send(ACT_LOAD, IDX_W'($urandom_range(0, 7)), FORCE_W'($urandom),
						THRUST_W'($urandom_range(1, 23'h7FFFFF)), 1'b0);
				else if (r == 1)
					send(ACT_CLEAR, IDX_W'($urandom), FORCE_W'($urandom), THRUST_W'($urandom),
						1'($urandom_range(0, 1)));
				else if (r == 2)
					send(ACT_UNUSED, IDX_W'($urandom), FORCE_W'($urandom), THRUST_W'($urandom),
						1'($urandom_range(0, 1)));
				else
					fire_random(ph % 2);
				if (n == 100) drain();
			end
			drain();
		end
		write_reg(REG_PERIOD, PERIOD_RST);
		write_reg(REG_MIN_FIRE, MIN_FIRE_RST);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
